[hw/rtl/line_segment_follow_controller_core_macros.svh]
// ----------------------------------------------------------------------------
// line segment follow controller assertion macros
// concurrent assertion wrappers, empty when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef LINE_SEGMENT_FOLLOW_CONTROLLER_CORE_MACROS_SVH
`define LINE_SEGMENT_FOLLOW_CONTROLLER_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define LSFC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("lsfc assertion failed");
`define LSFC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("lsfc assertion failed");
`else
`define LSFC_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define LSFC_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

[hw/rtl/lsfc_pkg.sv]
// ----------------------------------------------------------------------------
// lsfc_pkg
// shared constants, tables and types of the line segment follow controller
// ----------------------------------------------------------------------------
`default_nettype none
package lsfc_pkg;

	localparam int TURN_RATE_LIMIT_DEF   = 4;
	localparam int CORDIC_ITERATIONS_DEF = 14;

	// cordic datapath widths
	localparam int CX_W = 20;
	localparam int CZ_W = 24;

	localparam logic signed [17:0]     PI_Q13     = 18'sd25736;
	localparam logic signed [17:0]     TWO_PI_Q13 = 18'sd51472;
	localparam logic signed [CZ_W-1:0] PI_Q20     = 24'sd3294199;

	localparam int ATAN_ENTRIES = 20;
	localparam logic signed [CZ_W-1:0] ATAN_Q20 [ATAN_ENTRIES] = '{
		24'sd823550, 24'sd486170, 24'sd256879, 24'sd130396, 24'sd65451,
		24'sd32757,  24'sd16383,  24'sd8192,   24'sd4096,   24'sd2048,
		24'sd1024,   24'sd512,    24'sd256,    24'sd128,    24'sd64,
		24'sd32,     24'sd16,     24'sd8,      24'sd4,      24'sd2
	};

	// square root and cross-track divider
	localparam int SQRT_W     = 50;
	localparam int SQRT_STEPS = 25;
	localparam int LEN_W      = 25;
	localparam int DIV_W      = 44;
	localparam int DIV_QW     = 19;

	typedef enum logic [2:0] {
		REG_START_X   = 3'd0,
		REG_START_Y   = 3'd1,
		REG_END_X     = 3'd2,
		REG_END_Y     = 3'd3,
		REG_NOM_SPEED = 3'd4,
		REG_K_THETA   = 3'd5,
		REG_K_NORMAL  = 3'd6,
		REG_ARRIVE    = 3'd7
	} reg_idx_t;

	localparam logic signed [15:0] START_X_RST   = 16'sd0;
	localparam logic signed [15:0] START_Y_RST   = 16'sd0;
	localparam logic signed [15:0] END_X_RST     = 16'sd4096;
	localparam logic signed [15:0] END_Y_RST     = 16'sd0;
	localparam logic [11:0]        NOM_SPEED_RST = 12'd614;
	localparam logic signed [15:0] K_THETA_RST   = 16'sd1280;
	localparam logic signed [15:0] K_NORMAL_RST  = -16'sd12800;
	localparam logic [14:0]        ARRIVE_RST    = 15'd82;

	// one step of angle wrap into [-pi, pi]
	function automatic logic signed [17:0] wrap_once(input logic signed [17:0] a);
		logic signed [17:0] r;
		r = a;
		if (a >= PI_Q13)
			r = a - TWO_PI_Q13;
		else if (a <= -PI_Q13)
			r = a + TWO_PI_Q13;
		return r;
	endfunction

endpackage
`default_nettype wire

[hw/rtl/lsfc_cordic_cell.sv]
// ----------------------------------------------------------------------------
// lsfc_cordic_cell
// one registered vectoring step of the bearing cordic
// ----------------------------------------------------------------------------
`default_nettype none
module lsfc_cordic_cell import lsfc_pkg::*; #(
	parameter int IDX = 0,
	parameter int SW  = 1
) (
	input  logic                   clk,
	input  logic signed [CX_W-1:0] x_in,
	input  logic signed [CX_W-1:0] y_in,
	input  logic signed [CZ_W-1:0] z_in,
	input  logic [SW-1:0]          side_in,
	output logic signed [CX_W-1:0] x_out,
	output logic signed [CX_W-1:0] y_out,
	output logic signed [CZ_W-1:0] z_out,
	output logic [SW-1:0]          side_out
);

	logic signed [CX_W-1:0] xs, ys, x_n, y_n;
	logic signed [CZ_W-1:0] z_n;
	logic signed [CX_W-1:0] x_q, y_q;
	logic signed [CZ_W-1:0] z_q;
	logic [SW-1:0]          side_q;

	always_comb begin
		xs = x_in >>> IDX;
		ys = y_in >>> IDX;
		if (!y_in[CX_W-1]) begin
			x_n = x_in + ys;
			y_n = y_in - xs;
			z_n = z_in + ATAN_Q20[IDX];
		end else begin
			x_n = x_in - ys;
			y_n = y_in + xs;
			z_n = z_in - ATAN_Q20[IDX];
		end
	end

	always_ff @(posedge clk) begin
		x_q    <= x_n;
		y_q    <= y_n;
		z_q    <= z_n;
		side_q <= side_in;
	end

	assign x_out    = x_q;
	assign y_out    = y_q;
	assign z_out    = z_q;
	assign side_out = side_q;

endmodule
`default_nettype wire

[hw/rtl/lsfc_sqrt_cell.sv]
// ----------------------------------------------------------------------------
// lsfc_sqrt_cell
// one registered result bit of the digit-by-digit integer square root
// ----------------------------------------------------------------------------
`default_nettype none
module lsfc_sqrt_cell import lsfc_pkg::*; #(
	parameter int K  = 0,
	parameter int SW = 1
) (
	input  logic              clk,
	input  logic [SQRT_W-1:0] v_in,
	input  logic [SQRT_W-1:0] res_in,
	input  logic [SW-1:0]     side_in,
	output logic [SQRT_W-1:0] v_out,
	output logic [SQRT_W-1:0] res_out,
	output logic [SW-1:0]     side_out
);

	localparam logic [SQRT_W-1:0] BIT = {{(SQRT_W-1){1'b0}}, 1'b1} << (2*K);

	logic [SQRT_W-1:0] trial, v_n, res_n;
	logic [SQRT_W-1:0] v_q, res_q;
	logic [SW-1:0]     side_q;

	always_comb begin
		trial = res_in + BIT;
		if (v_in >= trial) begin
			v_n   = v_in - trial;
			res_n = (res_in >> 1) + BIT;
		end else begin
			v_n   = v_in;
			res_n = res_in >> 1;
		end
	end

	always_ff @(posedge clk) begin
		v_q    <= v_n;
		res_q  <= res_n;
		side_q <= side_in;
	end

	assign v_out    = v_q;
	assign res_out  = res_q;
	assign side_out = side_q;

endmodule
`default_nettype wire

[hw/rtl/lsfc_div_cell.sv]
// ----------------------------------------------------------------------------
// lsfc_div_cell
// one registered quotient bit of a restoring divider
// ----------------------------------------------------------------------------
`default_nettype none
module lsfc_div_cell #(
	parameter int W   = 8,
	parameter int QW  = 4,
	parameter int BIT = 0,
	parameter int SW  = 1
) (
	input  logic          clk,
	input  logic [W-1:0]  rem_in,
	input  logic [W-1:0]  den_in,
	input  logic [QW-1:0] q_in,
	input  logic [SW-1:0] side_in,
	output logic [W-1:0]  rem_out,
	output logic [W-1:0]  den_out,
	output logic [QW-1:0] q_out,
	output logic [SW-1:0] side_out
);

	logic [W-1:0]  sub, rem_n;
	logic [QW-1:0] q_n;
	logic [W-1:0]  rem_q, den_q;
	logic [QW-1:0] q_q;
	logic [SW-1:0] side_q;

	always_comb begin
		sub   = den_in << BIT;
		rem_n = rem_in;
		q_n   = q_in;
		if (rem_in >= sub) begin
			rem_n      = rem_in - sub;
			q_n[BIT]   = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		rem_q  <= rem_n;
		den_q  <= den_in;
		q_q    <= q_n;
		side_q <= side_in;
	end

	assign rem_out  = rem_q;
	assign den_out  = den_q;
	assign q_out    = q_q;
	assign side_out = side_q;

endmodule
`default_nettype wire

[hw/rtl/line_segment_follow_controller_core.sv]
// ----------------------------------------------------------------------------
// line_segment_follow_controller_core
// pose to turn rate and speed request for following a straight segment
// ----------------------------------------------------------------------------
// usage:
//   segment end points, gains, nominal speed and arrival radius sit behind
//   the apb port, one 32-bit register every 4 bytes, readable back.
//   a pose word (pos_x, pos_y, heading) is taken on each clock with start
//   high; busy stays low, so a new pose can enter on every cycle.
//   each pose gives one result word (turn_rate, speed, arrived), shown for
//   one cycle with done high. the pipeline is built from the cell chains:
//   25 square root cells, 19 divider cells for the cross-track distance and
//   12 divider cells for the speed scaling, plus front and back stages; the
//   bearing cordic runs in parallel. throughput is one pose per clock.
//   reset clears the valid pipeline and loads the default registers.
//   the receiver cannot stall: done is a strobe and is not held.
//   registers are to be changed only with no pose in flight; the block
//   itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none
`include "line_segment_follow_controller_core_macros.svh"
module line_segment_follow_controller_core import lsfc_pkg::*; #(
	parameter int TURN_RATE_LIMIT   = TURN_RATE_LIMIT_DEF,
	parameter int CORDIC_ITERATIONS = CORDIC_ITERATIONS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               start,
	output logic               busy,
	input  logic signed [15:0] pos_x,
	input  logic signed [15:0] pos_y,
	input  logic signed [15:0] heading,
	output logic               done,
	output logic signed [15:0] turn_rate,
	output logic [11:0]        speed,
	output logic               arrived
);

	localparam int CSIDE_W   = 17;
	localparam int SQSIDE_W  = 37;
	localparam int DSIDE_W   = 3;
	localparam int ETA_STAGE = CORDIC_ITERATIONS + 3;
	localparam int DIV_DONE  = 3 + SQRT_STEPS + DIV_QW;
	localparam int DL        = DIV_DONE - ETA_STAGE;
	localparam longint DEN   = longint'(TURN_RATE_LIMIT) * TURN_RATE_LIMIT * 65536;
	localparam int NUM_W     = $clog2(DEN + 1);
	localparam int PROD_W    = 12 + NUM_W;
	localparam int DVD_W     = PROD_W - 16;
	localparam int SDEN      = TURN_RATE_LIMIT * TURN_RATE_LIMIT;
	localparam int SDEN_W    = $clog2(SDEN + 1);
	localparam int SQW       = 12;
	localparam int SDIV_W    = (DVD_W > SDEN_W + SQW) ? DVD_W : SDEN_W + SQW;
	localparam int SPD_STEPS = SQW;
	localparam int SSIDE_W   = 17;
	localparam int LAST      = DIV_DONE + 5 + SPD_STEPS;

	// ---------------- configuration registers ----------------
	logic signed [15:0] start_x_q, start_y_q, end_x_q, end_y_q, k_theta_q, k_normal_q;
	logic [11:0]        nom_speed_q;
	logic [14:0]        arrive_q;
	logic               wr_en;

	assign wr_en  = psel && penable && pwrite && pready;
	assign pready = 1'b1;
	assign busy   = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_x_q   <= START_X_RST;
			start_y_q   <= START_Y_RST;
			end_x_q     <= END_X_RST;
			end_y_q     <= END_Y_RST;
			nom_speed_q <= NOM_SPEED_RST;
			k_theta_q   <= K_THETA_RST;
			k_normal_q  <= K_NORMAL_RST;
			arrive_q    <= ARRIVE_RST;
		end else if (wr_en) begin
			case (reg_idx_t'(paddr[4:2]))
				REG_START_X:   start_x_q   <= pwdata[15:0];
				REG_START_Y:   start_y_q   <= pwdata[15:0];
				REG_END_X:     end_x_q     <= pwdata[15:0];
				REG_END_Y:     end_y_q     <= pwdata[15:0];
				REG_NOM_SPEED: nom_speed_q <= pwdata[11:0];
				REG_K_THETA:   k_theta_q   <= pwdata[15:0];
				REG_K_NORMAL:  k_normal_q  <= pwdata[15:0];
				REG_ARRIVE:    arrive_q    <= pwdata[14:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx_t'(paddr[4:2]))
			REG_START_X:   prdata = {16'd0, start_x_q};
			REG_START_Y:   prdata = {16'd0, start_y_q};
			REG_END_X:     prdata = {16'd0, end_x_q};
			REG_END_Y:     prdata = {16'd0, end_y_q};
			REG_NOM_SPEED: prdata = {20'd0, nom_speed_q};
			REG_K_THETA:   prdata = {16'd0, k_theta_q};
			REG_K_NORMAL:  prdata = {16'd0, k_normal_q};
			REG_ARRIVE:    prdata = {17'd0, arrive_q};
			default:       prdata = '0;
		endcase
	end

	// ---------------- valid pipeline ----------------
	logic [LAST-1:0] vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			done  <= 1'b0;
		end else begin
			vld_q <= {vld_q[LAST-2:0], start && !busy};
			done  <= vld_q[LAST-1];
		end
	end

	// ---------------- stage 1: differences ----------------
	logic signed [16:0] ex_s1, ey_s1, ux_s1, uy_s1, rx_s1, ry_s1;
	logic signed [15:0] hw_s1;
	logic signed [17:0] hd_wrap;

	assign hd_wrap = wrap_once(18'(heading));

	always_ff @(posedge clk) begin
		ex_s1 <= 17'(end_x_q) - 17'(pos_x);
		ey_s1 <= 17'(end_y_q) - 17'(pos_y);
		ux_s1 <= 17'(end_x_q) - 17'(start_x_q);
		uy_s1 <= 17'(end_y_q) - 17'(start_y_q);
		rx_s1 <= 17'(pos_x) - 17'(start_x_q);
		ry_s1 <= 17'(pos_y) - 17'(start_y_q);
		hw_s1 <= 16'(hd_wrap);
	end

	// ---------------- stage 2: products, cordic preload ----------------
	logic signed [33:0] ex2_s2, ey2_s2, ux2_s2, uy2_s2, c1_s2, c2_s2;
	logic [29:0]        t2_s2;
	logic signed [CX_W-1:0] cx_s2, cy_s2;
	logic signed [CZ_W-1:0] cz_s2;
	logic [CSIDE_W-1:0]     cside_s2;

	always_ff @(posedge clk) begin
		ex2_s2 <= ex_s1 * ex_s1;
		ey2_s2 <= ey_s1 * ey_s1;
		ux2_s2 <= ux_s1 * ux_s1;
		uy2_s2 <= uy_s1 * uy_s1;
		c1_s2  <= ux_s1 * ry_s1;
		c2_s2  <= uy_s1 * rx_s1;
		t2_s2  <= arrive_q * arrive_q;
		// left half plane: rotate by pi first
		if (ex_s1[16]) begin
			cx_s2 <= -CX_W'(ex_s1);
			cy_s2 <= -CX_W'(ey_s1);
			cz_s2 <= ey_s1[16] ? -PI_Q20 : PI_Q20;
		end else begin
			cx_s2 <= CX_W'(ex_s1);
			cy_s2 <= CX_W'(ey_s1);
			cz_s2 <= '0;
		end
		cside_s2 <= {(ex_s1 == 17'sd0) && (ey_s1 == 17'sd0), hw_s1};
	end

	// ---------------- bearing cordic chain ----------------
	logic signed [CX_W-1:0] cx [0:CORDIC_ITERATIONS];
	logic signed [CX_W-1:0] cy [0:CORDIC_ITERATIONS];
	logic signed [CZ_W-1:0] cz [0:CORDIC_ITERATIONS];
	logic [CSIDE_W-1:0]     cs [0:CORDIC_ITERATIONS];

	assign cx[0] = cx_s2;
	assign cy[0] = cy_s2;
	assign cz[0] = cz_s2;
	assign cs[0] = cside_s2;

	for (genvar i = 0; i < CORDIC_ITERATIONS; i++) begin : g_cordic
		lsfc_cordic_cell #(.IDX(i), .SW(CSIDE_W)) u_cell (
			.clk      (clk),
			.x_in     (cx[i]),
			.y_in     (cy[i]),
			.z_in     (cz[i]),
			.side_in  (cs[i]),
			.x_out    (cx[i+1]),
			.y_out    (cy[i+1]),
			.z_out    (cz[i+1]),
			.side_out (cs[i+1])
		);
	end

	// heading error
	logic signed [CZ_W-1:0] z_rnd;
	logic signed [17:0]     brg, brg_w, err_w;
	logic signed [15:0]     eth_q;

	always_comb begin
		z_rnd = (cz[CORDIC_ITERATIONS] + 24'sd64) >>> 7;
		brg   = cs[CORDIC_ITERATIONS][16] ? 18'sd0 : 18'(z_rnd);
		brg_w = wrap_once(brg);
		err_w = wrap_once(brg_w - 18'($signed(cs[CORDIC_ITERATIONS][15:0])));
	end

	always_ff @(posedge clk) begin
		eth_q <= 16'(err_w);
	end

	// align heading error with the divider output
	logic signed [15:0] et_dly_q [0:DL-1];

	always_ff @(posedge clk) begin
		et_dly_q[0] <= eth_q;
		for (int k = 1; k < DL; k++)
			et_dly_q[k] <= et_dly_q[k-1];
	end

	// ---------------- stage 3: sums and arrival ----------------
	logic [32:0]        d2, len2;
	logic signed [34:0] crs;
	logic [33:0]        mag;
	logic [SQRT_W-1:0]  v_s3;
	logic [SQSIDE_W-1:0] sqside_s3;

	always_comb begin
		d2   = {1'b0, ex2_s2[31:0]} + {1'b0, ey2_s2[31:0]};
		len2 = {1'b0, ux2_s2[31:0]} + {1'b0, uy2_s2[31:0]};
		crs  = 35'(c1_s2) - 35'(c2_s2);
		mag  = crs[34] ? 34'(-crs) : 34'(crs);
	end

	always_ff @(posedge clk) begin
		v_s3      <= SQRT_W'({len2, 16'd0});
		sqside_s3 <= {d2 < 33'(t2_s2), crs[34], len2 == 33'd0, mag};
	end

	// ---------------- segment length square root chain ----------------
	logic [SQRT_W-1:0]   sv   [0:SQRT_STEPS];
	logic [SQRT_W-1:0]   sres [0:SQRT_STEPS];
	logic [SQSIDE_W-1:0] ssd  [0:SQRT_STEPS];

	assign sv[0]   = v_s3;
	assign sres[0] = '0;
	assign ssd[0]  = sqside_s3;

	for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
		lsfc_sqrt_cell #(.K(SQRT_STEPS - 1 - k), .SW(SQSIDE_W)) u_cell (
			.clk      (clk),
			.v_in     (sv[k]),
			.res_in   (sres[k]),
			.side_in  (ssd[k]),
			.v_out    (sv[k+1]),
			.res_out  (sres[k+1]),
			.side_out (ssd[k+1])
		);
	end

	// ---------------- cross-track divider chain ----------------
	logic [DIV_W-1:0]   drem [0:DIV_QW];
	logic [DIV_W-1:0]   dden [0:DIV_QW];
	logic [DIV_QW-1:0]  dq   [0:DIV_QW];
	logic [DSIDE_W-1:0] dsd  [0:DIV_QW];

	assign drem[0] = DIV_W'({ssd[SQRT_STEPS][33:0], 8'd0});
	assign dden[0] = DIV_W'(sres[SQRT_STEPS][LEN_W-1:0]);
	assign dq[0]   = '0;
	assign dsd[0]  = ssd[SQRT_STEPS][36:34];

	for (genvar j = 0; j < DIV_QW; j++) begin : g_div
		lsfc_div_cell #(.W(DIV_W), .QW(DIV_QW), .BIT(DIV_QW - 1 - j), .SW(DSIDE_W)) u_cell (
			.clk      (clk),
			.rem_in   (drem[j]),
			.den_in   (dden[j]),
			.q_in     (dq[j]),
			.side_in  (dsd[j]),
			.rem_out  (drem[j+1]),
			.den_out  (dden[j+1]),
			.q_out    (dq[j+1]),
			.side_out (dsd[j+1])
		);
	end

	// ---------------- turn request ----------------
	logic signed [DIV_QW:0] e_n;
	logic signed [31:0]     pt_s48;
	logic signed [35:0]     pn_s48;
	logic                   arr_s48;

	always_comb begin
		if (dsd[DIV_QW][0])
			e_n = '0;
		else if (dsd[DIV_QW][1])
			e_n = -$signed({1'b0, dq[DIV_QW]});
		else
			e_n = $signed({1'b0, dq[DIV_QW]});
	end

	always_ff @(posedge clk) begin
		pt_s48  <= k_theta_q * et_dly_q[DL-1];
		pn_s48  <= k_normal_q * e_n;
		arr_s48 <= dsd[DIV_QW][2];
	end

	logic signed [37:0] sum49, sh49;
	logic signed [15:0] turn_s49;
	logic               arr_s49;

	always_comb begin
		sum49 = 38'(pt_s48) + (38'(pn_s48) <<< 1) + 38'sd4096;
		sh49  = sum49 >>> 13;
	end

	always_ff @(posedge clk) begin
		if (sh49 > 38'sd32767)
			turn_s49 <= 16'sh7fff;
		else if (sh49 < -38'sd32768)
			turn_s49 <= 16'sh8000;
		else
			turn_s49 <= 16'(sh49);
		arr_s49 <= arr_s48;
	end

	// ---------------- speed request ----------------
	logic signed [31:0] tsq_full;
	logic [31:0]        tsq_s50;
	logic signed [15:0] turn_s50, turn_s51, turn_s52;
	logic               arr_s50, arr_s51, arr_s52;
	logic [NUM_W-1:0]   num_s51;
	logic [PROD_W-1:0]  prod_s52;

	assign tsq_full = turn_s49 * turn_s49;

	always_ff @(posedge clk) begin
		tsq_s50  <= $unsigned(tsq_full);
		turn_s50 <= turn_s49;
		arr_s50  <= arr_s49;
		num_s51  <= (32'(DEN) >= tsq_s50) ? NUM_W'(32'(DEN) - tsq_s50) : '0;
		turn_s51 <= turn_s50;
		arr_s51  <= arr_s50;
		prod_s52 <= PROD_W'(nom_speed_q) * PROD_W'(num_s51);
		turn_s52 <= turn_s51;
		arr_s52  <= arr_s51;
	end

	logic [SDIV_W-1:0]  srem [0:SPD_STEPS];
	logic [SDIV_W-1:0]  sden [0:SPD_STEPS];
	logic [SQW-1:0]     sq   [0:SPD_STEPS];
	logic [SSIDE_W-1:0] spd_sd [0:SPD_STEPS];

	assign srem[0]   = SDIV_W'(prod_s52[PROD_W-1:16]);
	assign sden[0]   = SDIV_W'(SDEN);
	assign sq[0]     = '0;
	assign spd_sd[0] = {arr_s52, turn_s52};

	for (genvar j = 0; j < SPD_STEPS; j++) begin : g_spd
		lsfc_div_cell #(.W(SDIV_W), .QW(SQW), .BIT(SQW - 1 - j), .SW(SSIDE_W)) u_cell (
			.clk      (clk),
			.rem_in   (srem[j]),
			.den_in   (sden[j]),
			.q_in     (sq[j]),
			.side_in  (spd_sd[j]),
			.rem_out  (srem[j+1]),
			.den_out  (sden[j+1]),
			.q_out    (sq[j+1]),
			.side_out (spd_sd[j+1])
		);
	end

	// ---------------- result register ----------------
	logic        arr_fin;

	assign arr_fin = spd_sd[SPD_STEPS][16];

	always_ff @(posedge clk) begin
		turn_rate <= arr_fin ? 16'sd0 : $signed(spd_sd[SPD_STEPS][15:0]);
		speed     <= arr_fin ? 12'd0 : sq[SPD_STEPS];
		arrived   <= arr_fin;
	end

	// ---------------- assertions ----------------
	`LSFC_ASSERT_IMP(a_eth_range, clk, arst_n, vld_q[ETA_STAGE-1],
		(eth_q >= -16'sd25736) && (eth_q <= 16'sd25736))
	`LSFC_ASSERT_IMP(a_div_rem, clk, arst_n, vld_q[DIV_DONE-1] && !dsd[DIV_QW][0],
		drem[DIV_QW] < dden[DIV_QW])
	`LSFC_ASSERT_NXT(a_arrive_zero, clk, arst_n, vld_q[LAST-1] && arr_fin,
		done && arrived && (turn_rate == 16'sd0) && (speed == 12'd0))

endmodule
`default_nettype wire

[verif/testbench.sv]
// ----------------------------------------------------------------------------
// line segment follow controller testbench
// poses are streamed with random gaps over a series of register settings;
// each result word is checked against a bit-exact predictor of bearing,
// cross-track distance, turn rate, speed and arrival
// ----------------------------------------------------------------------------
`default_nettype none
module testbench;
	import lsfc_pkg::*;

	localparam int  STEER_LIMIT  = 4;
	localparam int  BEARING_ITER = 14;
	localparam int  WATCHDOG_MAX = 2000;
	localparam int  DRAIN_CYCLES = 80;
	localparam longint PI_A      = 25736;
	localparam longint TWO_PI_A  = 51472;
	localparam longint PI_Z      = 3294199;

	typedef struct packed {
		logic signed [15:0] px;
		logic signed [15:0] py;
		logic signed [15:0] hd;
	} pose_t;

	typedef struct packed {
		logic signed [15:0] turn;
		logic [11:0]        spd;
		logic               arr;
	} steer_t;

	logic clk, arst_n;
	logic psel, penable, pwrite;
	logic [4:0] paddr;
	logic [31:0] pwdata, prdata;
	logic pready;
	logic start, busy;
	logic signed [15:0] pos_x, pos_y, heading;
	logic done;
	logic signed [15:0] turn_rate;
	logic [11:0] speed;
	logic arrived;

	line_segment_follow_controller_core u_top (.*);

	// register copy of the predictor
	logic signed [15:0] seg_sx, seg_sy, seg_ex, seg_ey, gain_th, gain_n;
	logic [11:0] nom_spd;
	logic [14:0] arr_rad;

	pose_t  pose_q[$];
	steer_t steer_q[$];
	int     errors;
	bit     no_gaps;
	int     gap;
	int     idle_cycles;

	const longint atan_tab[20] = '{823550, 486170, 256879, 130396, 65451, 32757,
		16383, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2};

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	// +pi maps to -pi and -pi maps to +pi
	function automatic longint wrap_pi(longint a);
		if (a >= PI_A) begin
			while (a >= PI_A)
				a -= TWO_PI_A;
		end else if (a <= -PI_A) begin
			while (a <= -PI_A)
				a += TWO_PI_A;
		end
		return a;
	endfunction

	function automatic longint bearing_of(longint x, longint y);
		longint z, xs, ys;
		z = 0;
		if (x == 0 && y == 0)
			return 0;
		if (x < 0) begin
			z = (y >= 0) ? PI_Z : -PI_Z;
			x = -x;
			y = -y;
		end
		for (int i = 0; i < BEARING_ITER && i < 20; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y >= 0) begin
				x = x + ys;
				y = y - xs;
				z += atan_tab[i];
			end else begin
				x = x - ys;
				y = y + xs;
				z -= atan_tab[i];
			end
		end
		return (z + 64) >>> 7;
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v -= res + b;
				res = (res >> 1) + b;
			end else
				res >>= 1;
			b >>= 2;
		end
		return res;
	endfunction

	function automatic steer_t steer_for(pose_t p);
		steer_t r;
		longint dx, dy, ux, uy, rx, ry, err, en, sum, trn, w0sq, num, crs;
		longint unsigned len2, mag, q;
		r = '0;
		dx = longint'(seg_ex) - p.px;
		dy = longint'(seg_ey) - p.py;
		if (dx * dx + dy * dy < longint'(arr_rad) * longint'(arr_rad)) begin
			r.arr = 1'b1;
			return r;
		end
		err = wrap_pi(wrap_pi(bearing_of(dx, dy)) - wrap_pi(p.hd));
		ux = longint'(seg_ex) - seg_sx;
		uy = longint'(seg_ey) - seg_sy;
		rx = longint'(p.px) - seg_sx;
		ry = longint'(p.py) - seg_sy;
		en = 0;
		len2 = ux * ux + uy * uy;
		if (len2 != 0) begin
			crs = ux * ry - uy * rx;
			mag = (crs < 0) ? -crs : crs;
			q = (mag << 8) / int_sqrt(len2 << 16);
			en = (crs < 0) ? -longint'(q) : longint'(q);
		end
		sum = longint'(gain_th) * err + 2 * longint'(gain_n) * en;
		trn = (sum + 4096) >>> 13;
		if (trn > 32767)
			trn = 32767;
		if (trn < -32768)
			trn = -32768;
		w0sq = (STEER_LIMIT * 256) * (STEER_LIMIT * 256);
		num = w0sq - trn * trn;
		if (num < 0)
			num = 0;
		r.turn = trn[15:0];
		r.spd = 12'((longint'(nom_spd) * num) / w0sq);
		return r;
	endfunction

	// pose driver
	always @(posedge clk or negedge arst_n) begin
		bit nxt;
		pose_t p;
		if (!arst_n) begin
			start <= 1'b0;
			pos_x <= '0;
			pos_y <= '0;
			heading <= '0;
			gap = 0;
		end else begin
			nxt = start;
			if (start && !busy) begin
				steer_q.push_back(steer_for({pos_x, pos_y, heading}));
				nxt = 1'b0;
			end
			if (!nxt) begin
				if (gap > 0)
					gap--;
				else if (pose_q.size() > 0) begin
					p = pose_q.pop_front();
					pos_x <= p.px;
					pos_y <= p.py;
					heading <= p.hd;
					nxt = 1'b1;
					gap = no_gaps ? 0 : $urandom_range(0, 3);
				end
			end
			start <= nxt;
		end
	end

	// result monitor
	always @(posedge clk) begin
		steer_t w;
		if (arst_n && done) begin
			if (steer_q.size() == 0) begin
				$display("%0t: unexpected result word turn %0d speed %0d arrived %0d",
					$time, turn_rate, speed, arrived);
				errors++;
			end else begin
				w = steer_q.pop_front();
				if (turn_rate !== w.turn) begin
					$display("%0t: turn_rate expected %0d actual %0d", $time, w.turn,
						turn_rate);
					errors++;
				end
				if (speed !== w.spd) begin
					$display("%0t: speed expected %0d actual %0d", $time, w.spd, speed);
					errors++;
				end
				if (arrived !== w.arr) begin
					$display("%0t: arrived expected %0d actual %0d", $time, w.arr,
						arrived);
					errors++;
				end
			end
		end
	end

	// watchdog on cycles with no traffic
	always @(posedge clk) begin
		if ((start && !busy) || done || psel || !arst_n)
			idle_cycles <= 0;
		else if (idle_cycles >= WATCHDOG_MAX) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end else
			idle_cycles <= idle_cycles + 1;
	end

	task automatic reg_write(reg_idx_t idx, logic [31:0] v);
		case (idx)
			REG_START_X:   seg_sx = v[15:0];
			REG_START_Y:   seg_sy = v[15:0];
			REG_END_X:     seg_ex = v[15:0];
			REG_END_Y:     seg_ey = v[15:0];
			REG_NOM_SPEED: nom_spd = v[11:0];
			REG_K_THETA:   gain_th = v[15:0];
			REG_K_NORMAL:  gain_n = v[15:0];
			REG_ARRIVE:    arr_rad = v[14:0];
			default: ;
		endcase
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= 5'(idx) << 2;
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic set_segment(logic [15:0] sx, sy, ex, ey, kt, kn, logic [11:0] ns,
			logic [14:0] th);
		reg_write(REG_START_X, {16'($urandom), sx});
		reg_write(REG_START_Y, {16'h0, sy});
		reg_write(REG_END_X, {16'h0, ex});
		reg_write(REG_END_Y, {16'h0, ey});
		reg_write(REG_NOM_SPEED, {20'h0, ns});
		reg_write(REG_K_THETA, {16'h0, kt});
		reg_write(REG_K_NORMAL, {16'h0, kn});
		reg_write(REG_ARRIVE, {17'h0, th});
	endtask

	task automatic add_pose(longint x, longint y, longint h);
		pose_t p;
		if (x > 32767) x = 32767;
		if (x < -32768) x = -32768;
		if (y > 32767) y = 32767;
		if (y < -32768) y = -32768;
		p.px = x[15:0];
		p.py = y[15:0];
		p.hd = h[15:0];
		pose_q.push_back(p);
	endtask

	task automatic add_random_poses(int n);
		longint h, t, off;
		for (int i = 0; i < n; i++) begin
			h = longint'($urandom_range(0, 51472)) - 25736;
			off = longint'(arr_rad) * 2 + 64;
			t = $urandom_range(0, 256);
			case ($urandom_range(0, 9))
				0, 1, 2: add_pose(seg_ex + longint'($urandom_range(0, 2 * off)) - off,
					seg_ey + longint'($urandom_range(0, 2 * off)) - off, h);
				3, 4, 5: add_pose(seg_sx + ((longint'(seg_ex) - seg_sx) * t) / 256
					+ longint'($urandom_range(0, 1024)) - 512,
					seg_sy + ((longint'(seg_ey) - seg_sy) * t) / 256
					+ longint'($urandom_range(0, 1024)) - 512, h);
				default: add_pose(longint'($signed(16'($urandom))),
					longint'($signed(16'($urandom))), h);
			endcase
		end
	endtask

	// wait for the pipeline to empty, then for the last result to clear
	task automatic drain();
		while (pose_q.size() > 0 || start || steer_q.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		errors = 0;
		no_gaps = 0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		seg_sx = START_X_RST;
		seg_sy = START_Y_RST;
		seg_ex = END_X_RST;
		seg_ey = END_Y_RST;
		nom_spd = NOM_SPEED_RST;
		gain_th = K_THETA_RST;
		gain_n = K_NORMAL_RST;
		arr_rad = ARRIVE_RST;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// default registers: arrival, heading extremes, field extremes
		add_pose(4096, 0, 0);
		add_pose(4100, 20, 25736);
		add_pose(0, 0, -25736);
		add_pose(-32768, -32768, 25736);
		add_pose(32767, 32767, -25736);
		add_pose(-32768, 32767, 0);
		add_pose(32767, -32768, 1);
		add_pose(8192, 0, -1);
		add_pose(8192, -1, 0);
		add_pose(2048, 300, -300);
		drain();

		// start on end, zero radius: normal distance zero, bearing zero on the end point
		set_segment(16'd1000, 16'd1000, 16'd1000, 16'd1000, 16'h7fff, 16'h8000, 12'hfff,
			15'd0);
		add_pose(1000, 1000, 25736);
		add_pose(1000, 1000, -25736);
		add_pose(2000, 1000, 0);
		add_pose(-32768, -32768, 0);
		add_pose(32767, 32767, 100);
		drain();

		// extreme segment and gains
		set_segment(16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 16'h7fff, 12'd0,
			15'h7fff);
		add_pose(32767, 32767, 0);
		add_pose(-32768, -32768, 0);
		add_pose(-32768, 32767, -25736);
		add_random_poses(150);
		drain();

		// random settings, two burst phases without gaps
		for (int ph = 0; ph < 10; ph++) begin
			no_gaps = (ph == 3) || (ph == 7);
			set_segment(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
				(ph % 3 == 0) ? 16'($urandom) : 16'($urandom_range(0, 4096)) - 16'd2048,
				(ph % 3 == 0) ? 16'($urandom) : 16'($urandom_range(0, 32768)) - 16'd16384,
				(ph == 5) ? 12'hfff : 12'($urandom),
				(ph == 6) ? 15'd0 : 15'($urandom_range(0, 4000)));
			add_random_poses(180);
			drain();
		end

		if (errors == 0 && steer_q.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
`default_nettype wire
